FILE: src/hbs_pkg.sv
// Shared constants for the heightfield bilinear sampler.
// Field widths, store geometry and default grid parameters; no dependencies.
package hbs_pkg;

	localparam int HEIGHT_W = 16;
	localparam int POS_W    = 21;
	localparam int STORE_AW = 12;
	localparam int INDEX_W  = 12;
	localparam int LIN_W    = 17;
	localparam int CMP_W    = 23;

	localparam int DEF_GRID_COLS  = 64;
	localparam int DEF_GRID_ROWS  = 64;
	localparam int DEF_SCALE_LOG2 = 2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

endpackage

FILE: src/heightfield_bilinear_sampler.sv
// Heightfield bilinear sampler top level: height store and interpolation pipeline.
// Depends on hbs_pkg.
//
// Usage: a request is taken at a rising edge with start high and busy low. busy is
// always low, so one request may be issued every cycle. func selects a height write
// (cell_index, height_value) or a query (pos_x, pos_z). Writes produce no result.
// A query drives interp_height and outside, with valid high, once it has passed the
// pipeline registers named below; throughput is one query per cycle.
// The grid is held twice, in two synchronous memories with two read ports each, so
// the four corner heights are fetched in the cycle after acceptance. A write reaches
// both copies at its accept edge, so a query issued in the next cycle sees it.
// Pipeline: corner read, weight products, height-times-weight products, sum and
// output register. Reset clears the valid pipeline only; the height store is
// undefined until written. The receiver cannot stall: each result is shown for one
// cycle only. Positions off the map return the most negative height with outside set.
module heightfield_bilinear_sampler #(
	parameter int GRID_COLS  = hbs_pkg::DEF_GRID_COLS,
	parameter int GRID_ROWS  = hbs_pkg::DEF_GRID_ROWS,
	parameter int SCALE_LOG2 = hbs_pkg::DEF_SCALE_LOG2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  func,
	input  logic [hbs_pkg::INDEX_W-1:0]           cell_index,
	input  logic signed [hbs_pkg::HEIGHT_W-1:0]   height_value,
	input  logic signed [hbs_pkg::POS_W-1:0]      pos_x,
	input  logic signed [hbs_pkg::POS_W-1:0]      pos_z,
	output logic                                  valid,
	output logic signed [hbs_pkg::HEIGHT_W-1:0]   interp_height,
	output logic                                  outside
);

	localparam int FRAC  = 8 + SCALE_LOG2;
	localparam int CW    = $clog2(GRID_COLS);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int WW    = 2 * FRAC + 1;
	localparam int ACC_W = hbs_pkg::HEIGHT_W + 2 * FRAC;
	localparam int HW    = hbs_pkg::HEIGHT_W;
	localparam int AW    = hbs_pkg::STORE_AW;
	localparam int LW    = hbs_pkg::LIN_W;
	localparam int XW    = hbs_pkg::CMP_W;
	localparam int DEPTH = 1 << AW;

	localparam logic [XW-1:0] X_MAX = XW'((GRID_COLS - 1) << FRAC);
	localparam logic [XW-1:0] Z_MAX = XW'((GRID_ROWS - 1) << FRAC);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
	localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

	logic [HW-1:0] mem_a [DEPTH];
	logic [HW-1:0] mem_b [DEPTH];

	logic          accept;
	logic          wr_en;
	logic          query;
	logic [XW-1:0] ux;
	logic [XW-1:0] uz;
	logic          off_map;
	logic [CW-1:0] col0, col1;
	logic [RW-1:0] row0, row1;
	logic [LW-1:0] lin00, lin01, lin10, lin11;

	logic            valid_s1, valid_s2, valid_s3;
	logic            out_s1, out_s2, out_s3;
	logic [FRAC-1:0] tx_s1, ty_s1;
	logic [HW-1:0]   h00_s1, h01_s1, h10_s1, h11_s1;
	logic [HW-1:0]   hb00_s2, hb01_s2, hb10_s2, hb11_s2;
	logic [WW-1:0]   w00_s2, w01_s2, w10_s2, w11_s2;
	logic [ACC_W-1:0] m00_s3, m01_s3, m10_s3, m11_s3;

	logic [FRAC:0]     wx0, wx1, wy0, wy1;
	logic [2*FRAC+1:0] p00, p01, p10, p11;
	logic [ACC_W:0]    q00, q01, q10, q11;
	logic [ACC_W-1:0]  acc;

	logic          valid_q;
	logic          outside_q;
	logic [HW-1:0] height_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_en  = accept && (func == hbs_pkg::FUNC_WRITE);
	assign query  = accept && (func == hbs_pkg::FUNC_QUERY);

	// x is used as is, z is negated so that rows grow away from the origin
	assign ux = {{(XW - hbs_pkg::POS_W){1'b0}}, pos_x};
	assign uz = XW'(-{{(XW - hbs_pkg::POS_W){pos_z[hbs_pkg::POS_W-1]}}, pos_z});

	always_comb begin
		off_map = pos_x[hbs_pkg::POS_W-1] || (ux > X_MAX)
			|| (!pos_z[hbs_pkg::POS_W-1] && (pos_z != '0)) || (uz > Z_MAX);
	end

	assign col0 = ux[FRAC +: CW];
	assign row0 = uz[FRAC +: RW];
	assign col1 = (col0 == COL_LAST) ? col0 : col0 + CW'(1);
	assign row1 = (row0 == ROW_LAST) ? row0 : row0 + RW'(1);

	assign lin00 = LW'(row0) * LW'(GRID_COLS) + LW'(col0);
	assign lin01 = LW'(row0) * LW'(GRID_COLS) + LW'(col1);
	assign lin10 = LW'(row1) * LW'(GRID_COLS) + LW'(col0);
	assign lin11 = LW'(row1) * LW'(GRID_COLS) + LW'(col1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[cell_index[AW-1:0]] <= height_value;
			mem_b[cell_index[AW-1:0]] <= height_value;
		end
		h00_s1 <= mem_a[lin00[AW-1:0]];
		h01_s1 <= mem_a[lin01[AW-1:0]];
		h10_s1 <= mem_b[lin10[AW-1:0]];
		h11_s1 <= mem_b[lin11[AW-1:0]];
	end

	assign wx1 = {1'b0, tx_s1};
	assign wy1 = {1'b0, ty_s1};
	assign wx0 = ONE - wx1;
	assign wy0 = ONE - wy1;
	assign p00 = wx0 * wy0;
	assign p01 = wx1 * wy0;
	assign p10 = wx0 * wy1;
	assign p11 = wx1 * wy1;

	// heights biased by 2^15 so every product is unsigned
	assign q00 = hb00_s2 * w00_s2;
	assign q01 = hb01_s2 * w01_s2;
	assign q10 = hb10_s2 * w10_s2;
	assign q11 = hb11_s2 * w11_s2;

	assign acc = m00_s3 + m01_s3 + m10_s3 + m11_s3;

	always_ff @(posedge clk) begin
		tx_s1   <= ux[FRAC-1:0];
		ty_s1   <= uz[FRAC-1:0];
		out_s1  <= off_map;
		hb00_s2 <= {~h00_s1[HW-1], h00_s1[HW-2:0]};
		hb01_s2 <= {~h01_s1[HW-1], h01_s1[HW-2:0]};
		hb10_s2 <= {~h10_s1[HW-1], h10_s1[HW-2:0]};
		hb11_s2 <= {~h11_s1[HW-1], h11_s1[HW-2:0]};
		w00_s2  <= p00[WW-1:0];
		w01_s2  <= p01[WW-1:0];
		w10_s2  <= p10[WW-1:0];
		w11_s2  <= p11[WW-1:0];
		out_s2  <= out_s1;
		m00_s3  <= q00[ACC_W-1:0];
		m01_s3  <= q01[ACC_W-1:0];
		m10_s3  <= q10[ACC_W-1:0];
		m11_s3  <= q11[ACC_W-1:0];
		out_s3  <= out_s2;
		outside_q <= out_s3;
		if (out_s3) begin
			height_q <= {1'b1, {(HW - 1){1'b0}}};
		end else begin
			height_q <= {~acc[ACC_W-1], acc[ACC_W-2 -: HW-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= query;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	assign valid         = valid_q;
	assign outside       = outside_q;
	assign interp_height = height_q;

endmodule

FILE: tb/hbs_scoreboard_pkg.sv
// Scoreboard for the heightfield bilinear sampler testbench: shadow height grid,
// sample predictor and in-order result check. Depends on hbs_pkg.
package hbs_scoreboard_pkg;
	import hbs_pkg::*;

	localparam int FRAC_W  = 8 + DEF_SCALE_LOG2;
	localparam int STORE_N = 1 << STORE_AW;
	localparam int X_MAX   = (DEF_GRID_COLS - 1) << FRAC_W;
	localparam int Z_DEPTH = (DEF_GRID_ROWS - 1) << FRAC_W;

	typedef logic signed [HEIGHT_W-1:0] height_t;
	typedef logic signed [POS_W-1:0]    pos_t;
	typedef logic [INDEX_W-1:0]         index_t;

	typedef struct {
		height_t height;
		logic    off_map;
	} sample_t;

	class height_scoreboard;
		height_t grid[STORE_N];
		sample_t expected_samples[$];
		int errors;
		int writes;
		int queries;
		int off_queries;

		function new();
			errors = 0;
			writes = 0;
			queries = 0;
			off_queries = 0;
		endfunction

		// Lower/upper corner columns and rows plus fractional weights; 0 when off the map.
		function bit locate(pos_t x, pos_t z, output int c0, output int c1, output int r0,
				output int r1, output longint unsigned fx, output longint unsigned fz);
			longint px;
			longint nz;
			px = x;
			nz = -longint'(z);
			c0 = 0;
			c1 = 0;
			r0 = 0;
			r1 = 0;
			fx = 0;
			fz = 0;
			if (px < 0 || px > X_MAX || nz < 0 || nz > Z_DEPTH)
				return 1'b0;
			c0 = int'(px >> FRAC_W);
			r0 = int'(nz >> FRAC_W);
			fx = longint'(px) & ((64'd1 << FRAC_W) - 1);
			fz = longint'(nz) & ((64'd1 << FRAC_W) - 1);
			c1 = (c0 + 1 > DEF_GRID_COLS - 1) ? DEF_GRID_COLS - 1 : c0 + 1;
			r1 = (r0 + 1 > DEF_GRID_ROWS - 1) ? DEF_GRID_ROWS - 1 : r0 + 1;
			return 1'b1;
		endfunction

		function index_t cell_of(int col, int row);
			return index_t'((row * DEF_GRID_COLS + col) % STORE_N);
		endfunction

		function longint unsigned biased(int col, int row);
			return longint'(grid[cell_of(col, row)]) + 32768;
		endfunction

		function sample_t predict_sample(pos_t x, pos_t z);
			sample_t s;
			int c0, c1, r0, r1;
			longint unsigned fx, fz, unit_w, acc;
			s.height = height_t'(16'h8000);
			s.off_map = 1'b1;
			if (!locate(x, z, c0, c1, r0, r1, fx, fz))
				return s;
			unit_w = 64'd1 << FRAC_W;
			acc = biased(c0, r0) * ((unit_w - fx) * (unit_w - fz))
				+ biased(c1, r0) * (fx * (unit_w - fz))
				+ biased(c0, r1) * ((unit_w - fx) * fz)
				+ biased(c1, r1) * (fx * fz);
			acc = acc >> (2 * FRAC_W);
			s.height = height_t'(acc - 32768);
			s.off_map = 1'b0;
			return s;
		endfunction

		function void note_request(logic f, index_t idx, height_t h, pos_t x, pos_t z);
			sample_t s;
			if (f == FUNC_WRITE) begin
				grid[idx] = h;
				writes++;
			end else begin
				s = predict_sample(x, z);
				expected_samples.push_back(s);
				queries++;
				if (s.off_map)
					off_queries++;
			end
		endfunction

		function void check_result(height_t h, logic o);
			sample_t s;
			if (expected_samples.size() == 0) begin
				$error("result with no query pending: interp_height %0d outside %0b", h, o);
				errors++;
				return;
			end
			s = expected_samples.pop_front();
			if (o !== s.off_map) begin
				$error("outside: expected %0b, got %0b", s.off_map, o);
				errors++;
			end
			if (h !== s.height) begin
				$error("interp_height: expected %0d, got %0d", s.height, h);
				errors++;
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		function void close_out();
			if (expected_samples.size() != 0) begin
				$error("%0d queries never answered", expected_samples.size());
				errors++;
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for heightfield_bilinear_sampler: directed and random height
// writes and queries, with sender idling. Depends on hbs_pkg and hbs_scoreboard_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hbs_pkg::*;
	import hbs_scoreboard_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	logic    func = FUNC_WRITE;
	index_t  cell_index = '0;
	height_t height_value = '0;
	pos_t    pos_x = '0;
	pos_t    pos_z = '0;
	logic    valid;
	height_t interp_height;
	logic    outside;

	height_scoreboard sb;
	bit cell_written[STORE_N];
	int idle_pct = 0;

	heightfield_bilinear_sampler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.cell_index   (cell_index),
		.height_value (height_value),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.valid        (valid),
		.interp_height(interp_height),
		.outside      (outside)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (valid)
				sb.check_result(interp_height, outside);
			if (start && !busy)
				sb.note_request(func, cell_index, height_value, pos_x, pos_z);
		end
	end

	task automatic hold_off();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			func <= 1'($urandom);
			cell_index <= index_t'($urandom);
			height_value <= height_t'($urandom);
			pos_x <= pos_t'($urandom);
			pos_z <= pos_t'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic issue(logic f, index_t idx, height_t h, pos_t x, pos_t z);
		hold_off();
		start <= 1'b1;
		func <= f;
		cell_index <= idx;
		height_value <= h;
		pos_x <= x;
		pos_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (f == FUNC_WRITE)
			cell_written[idx] = 1'b1;
	endtask

	task automatic write_height(index_t idx, height_t h);
		issue(FUNC_WRITE, idx, h, pos_t'($urandom), pos_t'($urandom));
	endtask

	// corners of an on-map query are loaded first so it never reads an unwritten entry
	task automatic query(pos_t x, pos_t z);
		int c0, c1, r0, r1;
		longint unsigned fx, fz;
		index_t corner[4];
		if (sb.locate(x, z, c0, c1, r0, r1, fx, fz)) begin
			corner[0] = sb.cell_of(c0, r0);
			corner[1] = sb.cell_of(c1, r0);
			corner[2] = sb.cell_of(c0, r1);
			corner[3] = sb.cell_of(c1, r1);
			foreach (corner[i])
				if (!cell_written[corner[i]])
					write_height(corner[i], height_t'($urandom));
		end
		issue(FUNC_QUERY, index_t'($urandom), height_t'($urandom), x, z);
	endtask

	function automatic pos_t pick_x();
		case ($urandom_range(7))
			0: return pos_t'(0);
			1: return pos_t'(X_MAX);
			2: return pos_t'(int'($urandom_range(DEF_GRID_COLS - 1)) << FRAC_W);
			default: return pos_t'(int'($urandom_range(X_MAX)));
		endcase
	endfunction

	function automatic pos_t pick_z();
		case ($urandom_range(7))
			0: return pos_t'(0);
			1: return pos_t'(-Z_DEPTH);
			2: return pos_t'(-(int'($urandom_range(DEF_GRID_ROWS - 1)) << FRAC_W));
			default: return pos_t'(-int'($urandom_range(Z_DEPTH)));
		endcase
	endfunction

	initial begin
		int phase_pct[3];
		int guard;
		int pick;
		phase_pct = '{0, 83, 13};
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_height(0, height_t'(16'h8000));
		write_height(1, height_t'(16'h7fff));
		write_height(index_t'(DEF_GRID_COLS), height_t'(16'h7fff));
		write_height(index_t'(DEF_GRID_COLS + 1), height_t'(16'h8000));
		query(0, 0);
		query(512, -512);
		query(pos_t'((1 << FRAC_W) - 1), pos_t'(-((1 << FRAC_W) - 1)));
		query(pos_t'(1 << FRAC_W), 0);
		write_height(index_t'(STORE_N - 1), height_t'(16'h7fff));
		write_height(index_t'(STORE_N - 2), height_t'(16'h8000));
		write_height(index_t'(STORE_N - 1 - DEF_GRID_COLS), height_t'(16'h8000));
		write_height(index_t'(STORE_N - 2 - DEF_GRID_COLS), height_t'(16'h7fff));
		query(pos_t'(X_MAX), pos_t'(-Z_DEPTH));
		query(pos_t'(X_MAX - 1), pos_t'(-(Z_DEPTH - 1)));
		query(pos_t'(X_MAX), 0);
		query(0, pos_t'(-Z_DEPTH));
		query(-1, 0);
		query(pos_t'(X_MAX + 1), 0);
		query(0, 1);
		query(0, pos_t'(-Z_DEPTH - 1));
		query(pos_t'(21'h0fffff), pos_t'(21'h0fffff));
		query(pos_t'(21'h100000), pos_t'(21'h100000));

		foreach (phase_pct[p]) begin
			idle_pct = phase_pct[p];
			repeat (100) begin
				pick = $urandom_range(99);
				if (pick < 20)
					write_height(index_t'($urandom), height_t'($urandom));
				else if (pick < 30)
					query(pos_t'($urandom), pos_t'($urandom));
				else
					query(pick_x(), pick_z());
			end
		end

		start <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 200) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		sb.close_out();
		$display("Ran %0d height writes and %0d queries (%0d off the map), idle 0/83/13 pct.",
			sb.writes, sb.queries, sb.off_queries);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: heightfield_bilinear_sampler.f
src/hbs_pkg.sv
src/heightfield_bilinear_sampler.sv
tb/hbs_scoreboard_pkg.sv
tb/tb_top.sv
